// ===== rtl/cv3_pkg.sv =====
`timescale 1ns / 1ps

package cv3_pkg;

	localparam int PIXEL_BITS  = 8;
	localparam int KERNEL_SIZE = 3;
	localparam int WIN_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
	localparam int WIN_EDGE    = KERNEL_SIZE - 1;
	localparam int PIXEL_MAX   = 255;
	localparam int MAX_HEIGHT  = 1024;

	localparam int IMG_W     = 11;   // image_width / image_height registers
	localparam int POS_W     = 10;   // row position and anchors
	localparam int COEF_W    = 8;
	localparam int KROW_W    = KERNEL_SIZE * COEF_W;
	localparam int DIV_W     = 8;
	localparam int PROD_W    = 17;   // signed coef x unsigned pixel
	localparam int RSUM_W    = 18;   // three products
	localparam int SUM_W     = 20;   // nine products
	localparam int PART_W    = DIV_W + PIXEL_BITS;  // dividend below divider * 256
	localparam int DIV_STEPS = PIXEL_BITS;
	localparam int CFG_IDX_W = 3;

	localparam logic [KROW_W-1:0] KROW_TOP_RST = 24'hFFFFFF;
	localparam logic [KROW_W-1:0] KROW_MID_RST = 24'h01FE01;
	localparam logic [KROW_W-1:0] KROW_BOT_RST = 24'h010101;
	localparam logic [DIV_W-1:0]  DIVIDER_RST  = 8'd1;
	localparam logic [IMG_W-1:0]  WIDTH_RST    = 11'd640;
	localparam logic [IMG_W-1:0]  HEIGHT_RST   = 11'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KROW_TOP = 3'd0,
		REG_KROW_MID = 3'd1,
		REG_KROW_BOT = 3'd2,
		REG_DIVIDER  = 3'd3,
		REG_WIDTH    = 3'd4,
		REG_HEIGHT   = 3'd5
	} cfg_reg_t;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] window_t;      // row major, tap 0 top-left
	typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel_t;       // entry 0 is the top row

	typedef struct packed {
		logic [POS_W-1:0] anchor_col;
		logic [POS_W-1:0] anchor_row;
		logic             done;
	} tag_t;

endpackage

// ===== rtl/cv3_ram.sv =====
`timescale 1ns / 1ps

module cv3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/cv3_window.sv =====
`timescale 1ns / 1ps

module cv3_window import cv3_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pixel_t           pixel,
	input  logic [IMG_W-1:0] image_width,
	input  logic [IMG_W-1:0] image_height,
	output logic             out_valid,
	input  logic             out_ready,
	output window_t          window,
	output tag_t             tag
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = ($clog2(MAX_WIDTH + 1) > IMG_W) ? $clog2(MAX_WIDTH + 1) : IMG_W;
	localparam int HW    = IMG_W;

	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] row_q;

	logic [WW-1:0]    iw, w_lim, col_ext, col_e, col_inc;
	logic [HW-1:0]    h_lim, row_w, row_e, row_inc;
	logic             accept, emit, done;
	tag_t             tag_new;

	logic             vld_s1, emit_s1;
	pixel_t           px_s1;
	logic [COL_W-1:0] addr_s1;
	tag_t             tag_s1;
	logic             mv1;

	logic             vld_s2, rdy_s2;
	window_t          win_s2;
	tag_t             tag_s2;

	logic [2*PIXEL_BITS-1:0] ls_rdata;
	pixel_t                  ls_up, ls_lo;

	// position of this pixel: wrap first in case the size shrank
	always_comb begin
		iw = WW'(image_width);
		if (iw < WW'(KERNEL_SIZE)) begin
			w_lim = WW'(KERNEL_SIZE);
		end else if (iw > WW'(MAX_WIDTH)) begin
			w_lim = WW'(MAX_WIDTH);
		end else begin
			w_lim = iw;
		end
		if (image_height < HW'(KERNEL_SIZE)) begin
			h_lim = HW'(KERNEL_SIZE);
		end else if (image_height > HW'(MAX_HEIGHT)) begin
			h_lim = HW'(MAX_HEIGHT);
		end else begin
			h_lim = image_height;
		end

		col_ext = WW'(col_q);
		row_w   = HW'(row_q);
		if (col_ext >= w_lim) begin
			col_e = '0;
			row_w = row_w + HW'(1);
		end else begin
			col_e = col_ext;
		end
		row_e = (row_w >= h_lim) ? '0 : row_w;

		col_inc = col_e + WW'(1);
		row_inc = row_e;
		if (col_inc >= w_lim) begin
			col_inc = '0;
			row_inc = row_e + HW'(1);
			if (row_inc >= h_lim) begin
				row_inc = '0;
			end
		end

		emit = (col_e >= WW'(WIN_EDGE)) && (row_e >= HW'(WIN_EDGE));
		done = (col_e == w_lim - WW'(1)) && (row_e == h_lim - HW'(1));
		tag_new.anchor_col = POS_W'(col_e - WW'(WIN_EDGE));
		tag_new.anchor_row = POS_W'(row_e - HW'(WIN_EDGE));
		tag_new.done       = done;
	end

	assign mv1      = vld_s1 && rdy_s2;
	assign in_ready = !vld_s1 || mv1;
	assign accept   = in_valid && in_ready;
	assign rdy_s2   = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_inc[COL_W-1:0];
			row_q <= row_inc[POS_W-1:0];
		end
	end

	// both line stores in one word: upper in the high byte
	cv3_ram #(
		.WIDTH(2 * PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (mv1),
		.waddr (addr_s1),
		.wdata ({ls_lo, px_s1}),
		.re    (accept),
		.raddr (col_e[COL_W-1:0]),
		.rdata (ls_rdata)
	);

	assign ls_up = ls_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
	assign ls_lo = ls_rdata[PIXEL_BITS-1:0];

	// s1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			addr_s1 <= col_e[COL_W-1:0];
			emit_s1 <= emit;
			tag_s1  <= tag_new;
		end
	end

	// s2: window shifts on every pixel, border pixels leave as bubbles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= mv1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
					win_s2[r*KERNEL_SIZE + c] <= win_s2[r*KERNEL_SIZE + c + 1];
				end
			end
			win_s2[KERNEL_SIZE-1]   <= ls_up;
			win_s2[2*KERNEL_SIZE-1] <= ls_lo;
			win_s2[3*KERNEL_SIZE-1] <= px_s1;
			tag_s2 <= tag_s1;
		end
	end

	assign out_valid = vld_s2;
	assign window    = win_s2;
	assign tag       = tag_s2;

endmodule

// ===== rtl/cv3_mac.sv =====
`timescale 1ns / 1ps

module cv3_mac import cv3_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  window_t                 window,
	input  tag_t                    tag_in,
	input  kernel_t                 kernel,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SUM_W-1:0] sum,
	output tag_t                    tag_out
);

	logic signed [PROD_W-1:0] prod_c [WIN_TAPS];
	logic signed [PROD_W-1:0] prod_s3 [WIN_TAPS];
	logic signed [RSUM_W-1:0] rsum_c [KERNEL_SIZE];
	logic signed [RSUM_W-1:0] rsum_s4 [KERNEL_SIZE];
	logic signed [SUM_W-1:0]  sum_s5;
	logic                     vld_s3, vld_s4, vld_s5;
	logic                     rdy_s3, rdy_s4, rdy_s5;
	tag_t                     tag_s3, tag_s4, tag_s5;
	logic signed [COEF_W-1:0]     cf;
	logic signed [PIXEL_BITS:0]   pv;

	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_comb begin
		cf = '0;
		pv = '0;
		for (int i = 0; i < WIN_TAPS; i++) begin
			cf = kernel[i / KERNEL_SIZE][(i % KERNEL_SIZE)*COEF_W +: COEF_W];
			pv = {1'b0, window[i]};
			prod_c[i] = PROD_W'(cf) * PROD_W'(pv);
		end
	end

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			rsum_c[r] = RSUM_W'(prod_s3[r*KERNEL_SIZE])
				+ RSUM_W'(prod_s3[r*KERNEL_SIZE + 1])
				+ RSUM_W'(prod_s3[r*KERNEL_SIZE + 2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				vld_s3 <= in_valid;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s3) begin
			prod_s3 <= prod_c;
			tag_s3  <= tag_in;
		end
		if (vld_s3 && rdy_s4) begin
			rsum_s4 <= rsum_c;
			tag_s4  <= tag_s3;
		end
		if (vld_s4 && rdy_s5) begin
			sum_s5 <= SUM_W'(rsum_s4[0]) + SUM_W'(rsum_s4[1]) + SUM_W'(rsum_s4[2]);
			tag_s5 <= tag_s4;
		end
	end

	assign out_valid = vld_s5;
	assign sum       = sum_s5;
	assign tag_out   = tag_s5;

endmodule

// ===== rtl/cv3_div.sv =====
`timescale 1ns / 1ps

module cv3_div import cv3_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [SUM_W-1:0] sum,
	input  tag_t                    tag_in,
	input  logic [DIV_W-1:0]        divider,
	output logic                    out_valid,
	input  logic                    out_ready,
	output pixel_t                  filtered,
	output tag_t                    tag_out
);

	// stage 0 is the range check, stages 1..DIV_STEPS one quotient bit each
	logic [DIV_STEPS:0]    vld_sk, rdy_sk;
	logic [PART_W-1:0]     part_sk [DIV_STEPS+1];
	pixel_t                quo_sk  [DIV_STEPS+1];
	logic                  zero_sk [DIV_STEPS+1];
	logic                  sat_sk  [DIV_STEPS+1];
	tag_t                  tag_sk  [DIV_STEPS+1];

	logic                  vld_q, rdy_out;
	pixel_t                filt_q;
	tag_t                  tag_q;

	logic [DIV_W-1:0]      d_eff;
	logic [SUM_W-1:0]      sum_u;
	logic [SUM_W-1:0]      sat_lim;
	logic                  zero_c, sat_c;

	// zero divides as one
	assign d_eff   = (divider == '0) ? DIV_W'(1) : divider;
	assign sum_u   = sum;
	assign sat_lim = SUM_W'({d_eff, {PIXEL_BITS{1'b0}}});
	// a quotient at or below zero clamps to zero, one of 256 or more to the maximum
	assign zero_c  = sum[SUM_W-1] || (sum == '0);
	assign sat_c   = !zero_c && (sum_u >= sat_lim);

	assign rdy_out = !vld_q || out_ready;
	assign rdy_sk[DIV_STEPS] = !vld_sk[DIV_STEPS] || rdy_out;
	assign rdy_sk[0] = !vld_sk[0] || rdy_sk[1];
	assign in_ready = rdy_sk[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[0] <= 1'b0;
		end else if (rdy_sk[0]) begin
			vld_sk[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_sk[0]) begin
			part_sk[0] <= sum_u[PART_W-1:0];
			quo_sk[0]  <= '0;
			zero_sk[0] <= zero_c;
			sat_sk[0]  <= sat_c;
			tag_sk[0]  <= tag_in;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		localparam int BIT = DIV_STEPS - k;

		logic [PART_W-1:0] dsh;
		logic              ge;
		logic [PART_W-1:0] part_c;
		pixel_t            quo_c;

		if (k < DIV_STEPS) begin : g_rdy
			assign rdy_sk[k] = !vld_sk[k] || rdy_sk[k+1];
		end

		always_comb begin
			dsh    = PART_W'(d_eff) << BIT;
			ge     = part_sk[k-1] >= dsh;
			part_c = ge ? (part_sk[k-1] - dsh) : part_sk[k-1];
			quo_c  = quo_sk[k-1];
			quo_c[BIT] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (rdy_sk[k]) begin
				vld_sk[k] <= vld_sk[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_sk[k-1] && rdy_sk[k]) begin
				part_sk[k] <= part_c;
				quo_sk[k]  <= quo_c;
				zero_sk[k] <= zero_sk[k-1];
				sat_sk[k]  <= sat_sk[k-1];
				tag_sk[k]  <= tag_sk[k-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy_out) begin
			vld_q <= vld_sk[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_sk[DIV_STEPS] && rdy_out) begin
			if (zero_sk[DIV_STEPS]) begin
				filt_q <= '0;
			end else if (sat_sk[DIV_STEPS]) begin
				filt_q <= PIXEL_BITS'(PIXEL_MAX);
			end else begin
				filt_q <= quo_sk[DIV_STEPS];
			end
			tag_q <= tag_sk[DIV_STEPS];
		end
	end

	assign out_valid = vld_q;
	assign filtered  = filt_q;
	assign tag_out   = tag_q;

endmodule

// ===== rtl/conv3x3_clamp_filter_unit.sv =====
`timescale 1ns / 1ps

// channel   | handshake                 | word
// ----------+---------------------------+----------------------------------------------
// pixel     | pixel_valid / pixel_stall | pixel_value
// result    | result_valid/result_stall | filtered_value, anchor_column, anchor_row,
//           |                           | frame_done
// config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One pixel word per clock is taken unless pixel_stall is high; a result word
// leaves after its window's last pixel passes line store read, window,
// products, row sums, total, range check, eight divide stages, output register.
// Border pixels produce no result and turn into bubbles after the window stage.
// Each stage holds while the one after it is full and stalled, so stalls back
// up stage by stage and bubbles still drain; pixel_stall rises only when the
// first stage is stuck. cfg_ready is always high.
// Reset restores the default kernel and sizes and the position to row 0,
// column 0; the line stores are not cleared (no clearing pass).

module conv3x3_clamp_filter_unit import cv3_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [PIXEL_BITS-1:0] pixel_value,

	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [PIXEL_BITS-1:0] filtered_value,
	output logic [POS_W-1:0]      anchor_column,
	output logic [POS_W-1:0]      anchor_row,
	output logic                  frame_done,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KROW_W-1:0]     cfg_data
);

	// configuration registers
	logic [KROW_W-1:0] krow_top_q, krow_mid_q, krow_bot_q;
	logic [DIV_W-1:0]  divider_q;
	logic [IMG_W-1:0]  width_q, height_q;

	kernel_t kernel;

	// window -> mac
	logic    win_valid, win_ready;
	window_t win;
	tag_t    win_tag;

	// mac -> div
	logic                    mac_valid, mac_ready;
	logic signed [SUM_W-1:0] mac_sum;
	tag_t                    mac_tag;

	pixel_t res_pixel;
	tag_t   res_tag;
	logic   pix_ready;

	assign cfg_ready = 1'b1;

	// writes to indexes beyond the list fall through and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krow_top_q <= KROW_TOP_RST;
			krow_mid_q <= KROW_MID_RST;
			krow_bot_q <= KROW_BOT_RST;
			divider_q  <= DIVIDER_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KROW_TOP: krow_top_q <= cfg_data;
				REG_KROW_MID: krow_mid_q <= cfg_data;
				REG_KROW_BOT: krow_bot_q <= cfg_data;
				REG_DIVIDER:  divider_q  <= cfg_data[DIV_W-1:0];
				REG_WIDTH:    width_q    <= cfg_data[IMG_W-1:0];
				REG_HEIGHT:   height_q   <= cfg_data[IMG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign kernel = {krow_bot_q, krow_mid_q, krow_top_q};

	// line stores, raster position and 3x3 window
	cv3_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pixel_valid),
		.in_ready     (pix_ready),
		.pixel        (pixel_value),
		.image_width  (width_q),
		.image_height (height_q),
		.out_valid    (win_valid),
		.out_ready    (win_ready),
		.window       (win),
		.tag          (win_tag)
	);

	assign pixel_stall = !pix_ready;

	// nine products and the adder tree
	cv3_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (win_valid),
		.in_ready  (win_ready),
		.window    (win),
		.tag_in    (win_tag),
		.kernel    (kernel),
		.out_valid (mac_valid),
		.out_ready (mac_ready),
		.sum       (mac_sum),
		.tag_out   (mac_tag)
	);

	// divide toward zero and clamp, ends in the output register
	cv3_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mac_valid),
		.in_ready  (mac_ready),
		.sum       (mac_sum),
		.tag_in    (mac_tag),
		.divider   (divider_q),
		.out_valid (result_valid),
		.out_ready (!result_stall),
		.filtered  (res_pixel),
		.tag_out   (res_tag)
	);

	assign filtered_value = res_pixel;
	assign anchor_column  = res_tag.anchor_col;
	assign anchor_row     = res_tag.anchor_row;
	assign frame_done     = res_tag.done;

endmodule

// ===== rtl/cv3_checker.sv =====
`timescale 1ns / 1ps

module cv3_checker import cv3_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [PIXEL_BITS-1:0] filtered_value,
	input logic [POS_W-1:0]      anchor_column,
	input logic [POS_W-1:0]      anchor_row,
	input logic                  frame_done
);

	// last delivered result; reset acts as the end of a frame
	logic             last_done_q;
	logic [POS_W-1:0] last_col_q, last_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_done_q <= 1'b1;
			last_col_q  <= '0;
			last_row_q  <= '0;
		end else if (result_valid && !result_stall) begin
			last_done_q <= frame_done;
			last_col_q  <= anchor_column;
			last_row_q  <= anchor_row;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(filtered_value)
			&& $stable(anchor_column) && $stable(anchor_row) && $stable(frame_done))
		else $error("stalled result word changed");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_done_q |-> anchor_column == '0 && anchor_row == '0)
		else $error("first word of a frame not anchored at the origin");

	a_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_done_q && anchor_row == last_row_q
			|-> anchor_column == POS_W'(last_col_q + POS_W'(1)))
		else $error("column skipped or repeated within a row");

	a_new_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_done_q && anchor_row != last_row_q |-> anchor_column == '0)
		else $error("new row does not start at column zero");

endmodule

bind conv3x3_clamp_filter_unit cv3_checker u_cv3_checker (.*);

// ===== bench/tb_conv3x3_clamp_filter_unit.sv =====
`timescale 1ns / 1ps

// Checks the 3x3 clamp filter against an in-bench convolution predictor.
// A short directed table comes first, then random frames under several
// kernel and size settings, with random idling and stalls on both channels.
module tb_conv3x3_clamp_filter_unit;
	import cv3_pkg::*;

	localparam int LINE_MAX    = 1024;  // line store depth of the instance
	localparam int DRAIN_WAIT  = 24;    // covers the pipe plus margin for bubbles
	localparam int QUIET_LIMIT = 1000;  // cycles with no handshake at all
	localparam int HOLD_CYCLES = 80;    // long receiver hold-off
	localparam int RANDOM_GOAL = 150;

	// indexes past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [KROW_W-1:0]      data;
		pixel_t                 px;
		logic                   typed;   // want holds a hand-read filtered value
		pixel_t                 want;
	} step_row_t;

	typedef struct packed {
		pixel_t           value;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last;
	} filt_word_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                 pixel_valid = 1'b0;
	logic                 pixel_stall;
	pixel_t               pixel_value = '0;

	logic                 result_valid;
	logic                 result_stall = 1'b0;
	pixel_t               filtered_value;
	logic [POS_W-1:0]     anchor_column;
	logic [POS_W-1:0]     anchor_row;
	logic                 frame_done;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KROW_W-1:0]    cfg_data = '0;

	conv3x3_clamp_filter_unit #(.MAX_WIDTH(LINE_MAX)) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.pixel_value    (pixel_value),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.filtered_value (filtered_value),
		.anchor_column  (anchor_column),
		.anchor_row     (anchor_row),
		.frame_done     (frame_done),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// ---------------------------------------------------------------
	// Predictor state: register copies, line stores, window, position
	// ---------------------------------------------------------------
	logic [KROW_W-1:0] krow [KERNEL_SIZE];
	logic [DIV_W-1:0]  div_reg;
	logic [IMG_W-1:0]  w_reg;
	logic [IMG_W-1:0]  h_reg;
	pixel_t            upper_line [LINE_MAX];
	pixel_t            lower_line [LINE_MAX];
	pixel_t            win [WIN_TAPS];
	int unsigned       col_pos;
	int unsigned       row_pos;

	filt_word_t pending_filtered[$];   // filtered words still owed by the block

	int mismatch_count = 0;
	int idle_pct       = 16;           // shared by sender gaps and receiver stalls
	int hold_requests  = 0;            // bumped by the stimulus to ask for a hold-off
	int hold_served    = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int random_items   = 0;

	// Directed part. Frame 1 and frame 2 are 3x3 frames under the reset kernel
	// (-1 -1 -1 / 1 -2 1 / 1 1 1): bright bottom row sums to +765 and clamps
	// high, bright top row sums to -765 and clamps to zero. Ahead of them the
	// sizes are written below range (both act as 3), the divider as zero
	// (acts as 1) and two writes go past the register list.
	step_row_t directed_steps [23] = '{
		'{ROW_CFG, REG_WIDTH,   24'd2,       8'd0,   1'b0, 8'd0},
		'{ROW_CFG, REG_HEIGHT,  24'd1,       8'd0,   1'b0, 8'd0},
		'{ROW_CFG, REG_DIVIDER, 24'd0,       8'd0,   1'b0, 8'd0},
		'{ROW_CFG, REG_SPARE1,  24'h000005,  8'd0,   1'b0, 8'd0},
		'{ROW_CFG, REG_SPARE0,  24'hFFFFFF,  8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd255, 1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd255, 1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd255, 1'b1, 8'd255},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd255, 1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd255, 1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd255, 1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_KROW_TOP, 24'd0,      8'd0,   1'b1, 8'd0}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic int unsigned eff_width();
		if (w_reg < 3) return 3;
		if (w_reg > LINE_MAX) return LINE_MAX;
		return w_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (h_reg < 3) return 3;
		if (h_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return h_reg;
	endfunction

	// pixels still to go before the next pixel lands on row 0, column 0
	function automatic int unsigned pixels_to_boundary();
		int unsigned w, h, c, r;
		w = eff_width();
		h = eff_height();
		c = col_pos;
		r = row_pos;
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h) r = 0;
		return (c == 0 && r == 0) ? 0 : w * h - (r * w + c);
	endfunction

	// Takes one pixel into the line stores and window; returns 1 with the
	// filtered word when the pixel completes a full window.
	function automatic bit convolve_pixel(input pixel_t px, output filt_word_t res);
		int unsigned w, h, c, r;
		int i, j, acc, q, d;
		pixel_t up, lo;
		logic signed [COEF_W-1:0] k;
		bit hit;
		w = eff_width();
		h = eff_height();
		res = '0;
		// a size shrunk mid-frame wraps the position before the pixel is taken
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		up = upper_line[c];
		lo = lower_line[c];
		upper_line[c] = lo;
		lower_line[c] = px;
		for (i = 0; i < KERNEL_SIZE; i++) begin
			win[3 * i]     = win[3 * i + 1];
			win[3 * i + 1] = win[3 * i + 2];
		end
		win[2] = up;
		win[5] = lo;
		win[8] = px;
		hit = (c >= WIN_EDGE && r >= WIN_EDGE);
		if (hit) begin
			acc = 0;
			d = (div_reg == 0) ? 1 : int'(div_reg);
			for (i = 0; i < KERNEL_SIZE; i++)
				for (j = 0; j < KERNEL_SIZE; j++) begin
					k = krow[i][COEF_W * j +: COEF_W];
					acc += int'(k) * int'(win[3 * i + j]);
				end
			q = acc / d;   // truncates toward zero
			if (q < 0) q = 0;
			if (q > PIXEL_MAX) q = PIXEL_MAX;
			res.value = q[PIXEL_BITS-1:0];
			res.col   = POS_W'(c - WIN_EDGE);
			res.row   = POS_W'(r - WIN_EDGE);
			res.last  = (c == w - 1 && r == h - 1);
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
		return hit;
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	// Offer one pixel word; valid stays up afterwards unless a gap follows.
	task automatic send_pixel(input pixel_t px, input bit typed = 1'b0,
			input pixel_t want = '0);
		int gap;
		filt_word_t res;
		gap = 0;
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_value <= px;
		do @(posedge clk); while (pixel_stall);
		if (convolve_pixel(px, res)) begin
			if (typed) res.value = want;
			pending_filtered.push_back(res);
		end
	endtask

	// Register write; valid is left up so back-to-back writes need no dip.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KROW_TOP: krow[0] = val;
			REG_KROW_MID: krow[1] = val;
			REG_KROW_BOT: krow[2] = val;
			REG_DIVIDER:  div_reg = val[DIV_W-1:0];
			REG_WIDTH:    w_reg   = val[IMG_W-1:0];
			REG_HEIGHT:   h_reg   = val[IMG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain_results();
		pixel_valid <= 1'b0;
		cfg_valid   <= 1'b0;
		while (pending_filtered.size() != 0) @(posedge clk);
	endtask

	// border pixels leave bubbles in the pipe after the last word
	task automatic settle();
		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic pixel_t random_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return pixel_t'($urandom);
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] pick_krow();
		logic [KROW_W-1:0] v;
		int i;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = 24'h7F7F7F;
			2: v = 24'h808080;
			3, 4: for (i = 0; i < KERNEL_SIZE; i++)
				v[COEF_W * i +: COEF_W] = COEF_W'($urandom_range(0, 16) - 8);
			default: v = KROW_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [DIV_W-1:0] pick_divider();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			default: return DIV_W'($urandom_range(2, 40));
		endcase
	endfunction

	// width may only grow at a frame boundary, or stale columns get read
	task automatic finish_frame();
		int n;
		n = pixels_to_boundary();
		repeat (n) send_pixel(random_pixel());
	endtask

	task automatic write_kernel_random();
		write_reg(REG_KROW_TOP, pick_krow());
		write_reg(REG_KROW_MID, pick_krow());
		write_reg(REG_KROW_BOT, pick_krow());
		write_reg(REG_DIVIDER, {16'($urandom), pick_divider()});
	endtask

	task automatic rand_phase();
		int n;
		finish_frame();
		settle();
		write_kernel_random();
		// junk above the size fields must be dropped
		write_reg(REG_WIDTH,  {13'($urandom), 11'($urandom_range(0, 9))});
		write_reg(REG_HEIGHT, {13'($urandom), 11'($urandom_range(0, 5))});
		n = eff_width() * eff_height() * $urandom_range(1, 2);
		if ($urandom_range(0, 3) == 0)
			n += $urandom_range(1, eff_width() * eff_height() - 1);
		repeat (n) begin
			send_pixel(random_pixel());
			random_items++;
		end
	endtask

	// Sizes shrunk mid-frame: first the column wraps into the next row,
	// later the row wraps back to zero with the column left mid-line.
	task automatic shrink_phase();
		finish_frame();
		settle();
		write_reg(REG_WIDTH, 24'd8);
		write_reg(REG_HEIGHT, 24'd6);
		repeat (29) send_pixel(random_pixel());   // next: row 3, column 5
		settle();
		write_reg(REG_WIDTH, 24'd5);
		write_reg(REG_HEIGHT, 24'd5);
		repeat (3) send_pixel(random_pixel());    // next: row 4, column 3
		settle();
		write_reg(REG_HEIGHT, 24'd4);
		finish_frame();
	endtask

	// Receiver holds off while pixels keep coming, so the pipe backs up into
	// pixel_stall; then the sender waits for every word before going on.
	task automatic pressure_phase();
		finish_frame();
		settle();
		write_reg(REG_WIDTH, 24'd4);
		write_reg(REG_HEIGHT, 24'd6);
		hold_requests++;
		repeat (72) send_pixel(random_pixel());
		drain_results();
		repeat (24) send_pixel(random_pixel());
	endtask

	// Longer line, no idling on either side.
	task automatic wide_phase();
		finish_frame();
		settle();
		idle_pct = 0;
		write_kernel_random();
		write_reg(REG_WIDTH, 24'd24);
		write_reg(REG_HEIGHT, 24'd3);
		repeat (72) send_pixel(random_pixel());
		idle_pct = 16;
	endtask

	// Height above the limit (2047 acts as 1024) on the narrowest line, then
	// cut to five lines mid-frame so the row wraps back to zero.
	task automatic tall_phase();
		finish_frame();
		settle();
		write_kernel_random();
		write_reg(REG_WIDTH, 24'd3);
		write_reg(REG_HEIGHT, 24'd2047);
		repeat (24) send_pixel(random_pixel());   // next: row 8, column 0
		settle();
		write_reg(REG_HEIGHT, 24'd5);
		repeat (15) send_pixel(random_pixel());
	endtask

	// ---------------------------------------------------------------
	// Receiver: random stalls plus the long hold-off on request
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// Result check: each accepted word against the oldest prediction
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin : check_results
		filt_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_filtered.size() == 0) begin
				report_mismatch("unexpected word, value", filtered_value, 0);
			end else begin
				want = pending_filtered.pop_front();
				if (filtered_value !== want.value)
					report_mismatch("filtered_value", filtered_value, want.value);
				if (anchor_column !== want.col)
					report_mismatch("anchor_column", anchor_column, want.col);
				if (anchor_row !== want.row)
					report_mismatch("anchor_row", anchor_row, want.row);
				if (frame_done !== want.last)
					report_mismatch("frame_done", frame_done, want.last);
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("conv3x3_clamp_filter_unit verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		int ph;
		krow[0] = KROW_TOP_RST;
		krow[1] = KROW_MID_RST;
		krow[2] = KROW_BOT_RST;
		div_reg = DIVIDER_RST;
		w_reg   = WIDTH_RST;
		h_reg   = HEIGHT_RST;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		foreach (win[i]) win[i] = '0;
		col_pos = 0;
		row_pos = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == ROW_CFG) begin
				settle();
				write_reg(directed_steps[i].idx, directed_steps[i].data);
			end else begin
				send_pixel(directed_steps[i].px, directed_steps[i].typed,
						directed_steps[i].want);
			end
		end

		// random frames with the special phases mixed in
		for (ph = 0; ph < 9 || random_items < RANDOM_GOAL; ph++) begin
			case (ph)
				2: shrink_phase();
				4: pressure_phase();
				6: wide_phase();
				8: tall_phase();
				default: rand_phase();
			endcase
		end

		drain_results();
		repeat (2 * DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("conv3x3_clamp_filter_unit verification clean");
		else
			$display("conv3x3_clamp_filter_unit verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cv3_pkg.sv
rtl/cv3_ram.sv
rtl/cv3_window.sv
rtl/cv3_mac.sv
rtl/cv3_div.sv
rtl/conv3x3_clamp_filter_unit.sv
rtl/cv3_checker.sv
bench/tb_conv3x3_clamp_filter_unit.sv
